@@ rtl/core/fpcm_pkg.sv @@
// Shared types, constants and the depth decoder for the float to PCM converter.
// Used by every module of the converter; depends on nothing else.
package fpcm_pkg;

  typedef enum logic [1:0] {
    MODE_16,
    MODE_24,
    MODE_PASS,
    MODE_ERR
  } mode_t;

  localparam logic [5:0] DEPTH_16    = 6'd16;
  localparam logic [5:0] DEPTH_24    = 6'd24;
  localparam logic [5:0] DEPTH_32    = 6'd32;
  localparam logic [5:0] DEPTH_RESET = DEPTH_32;

  localparam logic [23:0] SCALE16_NEG = 24'd32768;
  localparam logic [23:0] SCALE16_POS = 24'd32767;
  localparam logic [23:0] SCALE24_NEG = 24'd8388608;
  localparam logic [23:0] SCALE24_POS = 24'd8388607;

  localparam logic [7:0]  EXP_ONE     = 8'd127;
  localparam logic [7:0]  EXP_MAX     = 8'd255;
  localparam logic [7:0]  EXP_INT     = 8'd150;
  localparam logic [7:0]  SHIFT_LIMIT = 8'd48;
  localparam logic [23:0] MANT_ONE    = 24'h800000;

  localparam logic [4:0] DROP16_LO = 5'd14;
  localparam logic [4:0] DROP16_HI = 5'd15;
  localparam logic [4:0] DROP24_LO = 5'd22;
  localparam logic [4:0] DROP24_HI = 5'd23;

  typedef struct packed {
    mode_t       mode;
    logic        neg;
    logic [7:0]  expo;
    logic [47:0] prod;
    logic [31:0] raw;
  } prod_t;

  function automatic mode_t decode_depth(logic [5:0] depth);
    mode_t m;
    unique case (depth)
      DEPTH_16: m = MODE_16;
      DEPTH_24: m = MODE_24;
      DEPTH_32: m = MODE_PASS;
      default:  m = MODE_ERR;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/core/fpcm_if.sv @@
// Valid/ready channel interfaces for float samples in and PCM words out.
// Stand-alone; no package needed.
interface fpcm_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_bits;
  modport source (output valid, output sample_bits, input ready);
  modport sink (input valid, input sample_bits, output ready);
endinterface

interface fpcm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pcm_word;
  logic        depth_error;
  modport source (output valid, output pcm_word, output depth_error, input ready);
  modport sink (input valid, input pcm_word, input depth_error, output ready);
endinterface

@@ rtl/core/fpcm_scale.sv @@
// Clamp stage and scale multiplier, registered into the product stage.
// Depends on fpcm_pkg.
module fpcm_scale (
  input  logic              clk,
  input  logic              en,
  input  logic [5:0]        depth,
  input  logic [31:0]       sample,
  output fpcm_pkg::prod_t   q
);

  logic                  sgn;
  logic [7:0]            e;
  logic [22:0]           f;
  logic                  is_nan;
  logic                  over;
  logic                  neg;
  logic [23:0]           m;
  logic [7:0]            ee;
  logic [23:0]           k;
  fpcm_pkg::mode_t       mode;
  fpcm_pkg::prod_t       q_next;

  assign sgn = sample[31];
  assign e   = sample[30:23];
  assign f   = sample[22:0];

  always_comb begin
    is_nan = (e == fpcm_pkg::EXP_MAX) && (f != '0);
    over   = (e > fpcm_pkg::EXP_ONE) || ((e == fpcm_pkg::EXP_ONE) && (f != '0));
    if (is_nan) begin
      neg = 1'b0;
      m   = fpcm_pkg::MANT_ONE;
      ee  = fpcm_pkg::EXP_ONE;
    end else if (over) begin
      neg = sgn;
      m   = fpcm_pkg::MANT_ONE;
      ee  = fpcm_pkg::EXP_ONE;
    end else if (e == '0) begin
      neg = 1'b0;
      m   = '0;
      ee  = '0;
    end else begin
      neg = sgn;
      m   = {1'b1, f};
      ee  = e;
    end
    mode = fpcm_pkg::decode_depth(depth);
    if (mode == fpcm_pkg::MODE_24) begin
      k = neg ? fpcm_pkg::SCALE24_NEG : fpcm_pkg::SCALE24_POS;
    end else begin
      k = neg ? fpcm_pkg::SCALE16_NEG : fpcm_pkg::SCALE16_POS;
    end
    q_next.mode = mode;
    q_next.neg  = neg;
    q_next.expo = ee;
    q_next.prod = m * k;
    q_next.raw  = sample;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

@@ rtl/core/fpcm_round.sv @@
// Rounds the product to single precision, truncates to an integer and packs the word.
// Depends on fpcm_pkg.
module fpcm_round (
  input  logic              clk,
  input  logic              en,
  input  fpcm_pkg::prod_t   p,
  output logic [31:0]       pcm_word,
  output logic              depth_error
);

  logic        wide;
  logic        top_hi;
  logic [4:0]  drop;
  logic [48:0] full;
  logic [48:0] unit;
  logic [48:0] mask;
  logic [48:0] kept;
  logic        half;
  logic        lsb;
  logic        sticky;
  logic [48:0] rnd;
  logic [7:0]  sh;
  logic [48:0] shifted;
  logic [24:0] mag;
  logic [31:0] val;
  logic [31:0] pcm_word_next;

  always_comb begin
    wide   = (p.mode == fpcm_pkg::MODE_24);
    top_hi = wide ? p.prod[46] : p.prod[38];
    if (wide) begin
      drop = top_hi ? fpcm_pkg::DROP24_HI : fpcm_pkg::DROP24_LO;
    end else begin
      drop = top_hi ? fpcm_pkg::DROP16_HI : fpcm_pkg::DROP16_LO;
    end
    full   = {1'b0, p.prod};
    unit   = 49'd1 << drop;
    mask   = unit - 49'd1;
    kept   = full & ~mask;
    half   = |(full & (unit >> 1));
    lsb    = |(full & unit);
    sticky = |(full & (mask >> 1));
    rnd    = kept + ((half && (sticky || lsb)) ? unit : '0);
    sh     = fpcm_pkg::EXP_INT - p.expo;
    shifted = (sh >= fpcm_pkg::SHIFT_LIMIT) ? '0 : (rnd >> sh);
    mag    = shifted[24:0];
    val    = p.neg ? (32'd0 - {7'd0, mag}) : {7'd0, mag};
    case (p.mode)
      fpcm_pkg::MODE_16:   pcm_word_next = {16'd0, val[15:0]};
      fpcm_pkg::MODE_24:   pcm_word_next = {8'd0, val[23:0]};
      fpcm_pkg::MODE_PASS: pcm_word_next = p.raw;
      default:             pcm_word_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pcm_word    <= pcm_word_next;
      depth_error <= (p.mode == fpcm_pkg::MODE_ERR);
    end
  end

endmodule

@@ rtl/core/float_to_pcm_sample_converter.sv @@
// Top level of the float32 to PCM16/PCM24 converter: depth register and pipeline control.
// Depends on fpcm_pkg, fpcm_if, fpcm_scale and fpcm_round.
//
//   channel      dir   beat contents
//   sample_in    in    sample_bits[31:0]
//   pcm_out      out   pcm_word[31:0], depth_error
//   cfg_we/wdata in    output_depth[5:0], no handshake
//
// One beat is accepted per cycle unless pcm_out stalls; an accepted beat is first held in an input register.
// The multiplier stage and the rounding stage each hold one register level.
// A stall on pcm_out holds the pipeline, and sample_in.ready drops only once every stage is full.
// Reset is synchronous: it empties the pipeline and sets the depth to 32.
module float_to_pcm_sample_converter (
  input  logic            clk,
  input  logic            rst,
  fpcm_in_if.sink         sample_in,
  fpcm_out_if.source      pcm_out,
  input  logic            cfg_we,
  input  logic [5:0]      cfg_wdata
);

  logic [5:0]       depth;
  logic             s1_valid;
  logic [31:0]      s1_bits;
  logic             s2_valid;
  logic             out_valid;
  logic             out_take;
  logic             s2_take;
  logic             s1_take;
  fpcm_pkg::prod_t  s2_prod;

  assign out_take        = !out_valid || pcm_out.ready;
  assign s2_take         = !s2_valid || out_take;
  assign s1_take         = !s1_valid || s2_take;
  assign sample_in.ready = s1_take;
  assign pcm_out.valid   = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= fpcm_pkg::DEPTH_RESET;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        depth <= cfg_wdata;
      end
      if (s1_take) begin
        s1_valid <= sample_in.valid;
      end
      if (s2_take) begin
        s2_valid <= s1_valid;
      end
      if (out_take) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_bits <= sample_in.sample_bits;
    end
  end

  fpcm_scale u_scale (
    .clk    (clk),
    .en     (s2_take),
    .depth  (depth),
    .sample (s1_bits),
    .q      (s2_prod)
  );

  fpcm_round u_round (
    .clk         (clk),
    .en          (out_take),
    .p           (s2_prod),
    .pcm_word    (pcm_out.pcm_word),
    .depth_error (pcm_out.depth_error)
  );

  // An unsupported depth always yields a zero word.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    pcm_out.valid && pcm_out.depth_error |-> pcm_out.pcm_word == '0)
    else $error("depth error with nonzero word");

  // A beat held in the first stage is not dropped while the next stage is blocked.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_take |=> s1_valid)
    else $error("first stage lost a beat");

  // Input is refused only when every stage holds a beat.
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !sample_in.ready |-> s1_valid && s2_valid && out_valid && !pcm_out.ready)
    else $error("input stalled with room in the pipeline");

endmodule
